>>> hw/rtl/knn_delta_prefetcher_top_assert.svh
// Assertion macros for the delta prefetcher.
`ifndef KNN_DELTA_PREFETCHER_TOP_ASSERT_SVH
`define KNN_DELTA_PREFETCHER_TOP_ASSERT_SVH
// Same-cycle implication, checked outside reset.
`define KDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prefetcher assertion failed");
// Next-cycle implication, checked outside reset.
`define KDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prefetcher assertion failed");
`endif

>>> hw/rtl/kdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdp_pkg
// Types and constants of the nearest-neighbour delta prefetcher.
// ----------------------------------------------------------------------------
package kdp_pkg;

    localparam int LOG_DEPTH_DEF  = 512;
    localparam int NEIGHBOURS_DEF = 5;

    localparam logic [23:0] WINDOW_RESET = 24'd5000;
    localparam logic [31:0] LIMIT_RESET  = 32'hFFFF_FFFF;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    localparam logic [32:0] DIST_INF = 33'h1_0000_0000;

    typedef struct packed {
        logic [31:0] access_pc;
        logic [31:0] access_addr;
        logic [47:0] access_time;
    } t_access;

    typedef struct packed {
        logic [31:0] prefetch_addr;
        logic        prefetch_valid;
    } t_prefetch;

    typedef struct packed {
        logic [31:0] entry_pc;
        logic [31:0] entry_addr;
        logic [47:0] entry_time;
        logic [31:0] entry_delta;
        logic        entry_trained;
    } t_entry;

endpackage

>>> hw/rtl/knn_delta_prefetcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_delta_prefetcher_top
// Trains at most one aged log entry per access, appends the access and
// picks the delta of the nearest trained entry by program counter distance.
//
// Channel   Direction  Handshake         Payload
// access    in         i_valid/o_stall   i_access (kdp_pkg::t_access)
// prefetch  out        o_valid/i_stall   o_prefetch (kdp_pkg::t_prefetch)
// config    in         i_cfg_we          i_cfg_idx, i_cfg_data
//
// The backward walk reads one log entry per cycle, the neighbour scan reads
// every entry through the single memory read port. After reset a clearing
// pass zeroes the log before the first item is taken. A stalled result
// holds in the output register while the next item is already accepted
// and worked on.
// ----------------------------------------------------------------------------
`include "knn_delta_prefetcher_top_assert.svh"

module knn_delta_prefetcher_top #(
    parameter int LOG_DEPTH  = kdp_pkg::LOG_DEPTH_DEF,
    parameter int NEIGHBOURS = kdp_pkg::NEIGHBOURS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  kdp_pkg::t_access   i_access,
    output logic               o_valid,
    input  logic               i_stall,
    output kdp_pkg::t_prefetch o_prefetch,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int NW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
    localparam logic [AW-1:0] LAST     = AW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(LOG_DEPTH);
    localparam logic [CW-1:0] FILL_MAX = CW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] ONE_C    = CW'(1);

    localparam logic [2:0] ST_CLR    = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    kdp_pkg::t_entry r_mem [LOG_DEPTH];

    logic [2:0]         r_state;
    logic [AW-1:0]      r_clr;
    logic [23:0]        r_window;
    logic [31:0]        r_limit;
    logic [AW-1:0]      r_wp;
    logic [CW-1:0]      r_fill;
    logic [31:0]        r_pc;
    logic [31:0]        r_addr;
    logic [47:0]        r_time;
    logic               r_below;
    logic [47:0]        r_thr;
    logic [AW-1:0]      r_ptr;
    logic [CW-1:0]      r_issue;
    logic [CW-1:0]      r_chk;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_ptr;
    kdp_pkg::t_entry    r_rd_data;
    logic [31:0]        r_d;
    logic               r_d_trn;
    logic [31:0]        r_d_delta;
    logic               r_d_vld;
    logic               r_s_used  [NEIGHBOURS];
    logic [31:0]        r_s_dist  [NEIGHBOURS];
    logic [31:0]        r_s_delta [NEIGHBOURS];
    logic               r_any;
    logic               r_o_valid;
    kdp_pkg::t_prefetch r_o_item;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    kdp_pkg::t_entry    mem_wd;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               hit;
    logic [31:0]        pc_dist;
    logic [32:0]        lg;
    logic [NW-1:0]      li;
    logic               ins;
    logic [32:0]        best;
    logic [NW-1:0]      sel;
    logic               found;
    logic [31:0]        pf;
    logic [AW-1:0]      ptr_dec;
    logic [AW-1:0]      wp_dec;
    logic [AW-1:0]      wp_inc;

    assign ptr_dec = (r_ptr == '0) ? LAST : r_ptr - AW'(1);
    assign wp_dec  = (r_wp == '0) ? LAST : r_wp - AW'(1);
    assign wp_inc  = (r_wp == LAST) ? '0 : r_wp + AW'(1);

    assign hit     = r_rd_vld && (r_below || (r_rd_data.entry_time <= r_thr));
    assign pc_dist = (r_pc >= r_rd_data.entry_pc) ? r_pc - r_rd_data.entry_pc
                                                  : r_rd_data.entry_pc - r_pc;

    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_wp;
        mem_wd  = '0;
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        case (r_state)
            ST_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            ST_WALK: begin
                rd_en = (r_issue != '0);
                if (hit) begin
                    mem_we               = 1'b1;
                    mem_wa               = r_rd_ptr;
                    mem_wd               = r_rd_data;
                    mem_wd.entry_trained = 1'b1;
                    mem_wd.entry_delta   = r_addr - r_rd_data.entry_addr;
                end
            end
            ST_APPEND: begin
                mem_we            = 1'b1;
                mem_wa            = r_wp;
                mem_wd.entry_pc   = r_pc;
                mem_wd.entry_addr = r_addr;
                mem_wd.entry_time = r_time;
            end
            ST_SCAN: begin
                rd_en = (r_issue != '0);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        lg = kdp_pkg::DIST_INF;
        li = '0;
        if (r_any) begin
            lg = '0;
            for (int u = 0; u < NEIGHBOURS; u++) begin
                if (!r_s_used[u]) begin
                    lg = kdp_pkg::DIST_INF;
                    li = NW'(u);
                end else if ({1'b0, r_s_dist[u]} > lg) begin
                    lg = {1'b0, r_s_dist[u]};
                    li = NW'(u);
                end
            end
        end
        ins = (r_state == ST_SCAN) && r_d_vld && r_d_trn && ({1'b0, r_d} < lg);
    end

    always_comb begin
        best  = kdp_pkg::DIST_INF;
        sel   = '0;
        found = 1'b0;
        for (int u = 0; u < NEIGHBOURS; u++) begin
            if (r_s_used[u] && ({1'b0, r_s_dist[u]} < best)) begin
                best  = {1'b0, r_s_dist[u]};
                sel   = NW'(u);
                found = 1'b1;
            end
        end
        pf = r_addr + r_s_delta[sel];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr  <= rd_addr;
        r_d       <= pc_dist;
        r_d_trn   <= r_rd_data.entry_trained;
        r_d_delta <= r_rd_data.entry_delta;
        if (ins) begin
            r_s_dist[li]  <= r_d;
            r_s_delta[li] <= r_d_delta;
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_pc    <= i_access.access_pc;
            r_addr  <= i_access.access_addr;
            r_time  <= i_access.access_time;
            r_below <= i_access.access_time < {24'd0, r_window};
            r_thr   <= i_access.access_time - {24'd0, r_window};
        end
        if (r_state == ST_OUT && (!r_o_valid || !i_stall)) begin
            r_o_item.prefetch_addr  <= found ? pf : 32'd0;
            r_o_item.prefetch_valid <= found && (pf < r_limit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr     <= '0;
            r_window  <= kdp_pkg::WINDOW_RESET;
            r_limit   <= kdp_pkg::LIMIT_RESET;
            r_wp      <= '0;
            r_fill    <= '0;
            r_ptr     <= '0;
            r_issue   <= '0;
            r_chk     <= '0;
            r_rd_vld  <= 1'b0;
            r_d_vld   <= 1'b0;
            r_any     <= 1'b0;
            r_o_valid <= 1'b0;
            for (int u = 0; u < NEIGHBOURS; u++) begin
                r_s_used[u] <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == kdp_pkg::CFG_WINDOW) begin
                    r_window <= i_cfg_data[23:0];
                end else begin
                    r_limit <= i_cfg_data;
                end
            end
            r_rd_vld <= rd_en;
            r_d_vld  <= (r_state == ST_SCAN) && r_rd_vld;
            if (ins) begin
                r_any        <= 1'b1;
                r_s_used[li] <= 1'b1;
            end
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_clr <= (r_clr == LAST) ? '0 : r_clr + AW'(1);
                    if (r_clr == LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_ptr   <= wp_dec;
                        r_issue <= r_fill + ONE_C;
                        r_chk   <= r_fill + ONE_C;
                        r_any   <= 1'b0;
                        for (int u = 0; u < NEIGHBOURS; u++) begin
                            r_s_used[u] <= 1'b0;
                        end
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (rd_en) begin
                        r_ptr   <= ptr_dec;
                        r_issue <= r_issue - ONE_C;
                    end
                    if (r_rd_vld) begin
                        r_chk <= r_chk - ONE_C;
                        if (hit || r_chk == ONE_C) begin
                            r_state <= ST_APPEND;
                        end
                    end
                end
                ST_APPEND: begin
                    r_ptr   <= '0;
                    r_issue <= DEPTH_C;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        r_ptr   <= (r_ptr == LAST) ? '0 : r_ptr + AW'(1);
                        r_issue <= r_issue - ONE_C;
                    end
                    if (r_issue == '0 && !r_rd_vld && !r_d_vld) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_wp      <= wp_inc;
                        r_fill    <= (r_fill >= FILL_MAX - ONE_C) ? FILL_MAX
                                                                 : r_fill + ONE_C;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_o_valid;
    assign o_prefetch = r_o_item;

    `KDP_ASSERT_NEXT(a_accept_walks, i_valid && !o_stall, r_state == ST_WALK)
    `KDP_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_MAX)
    `KDP_ASSERT_NOW(a_pf_below_limit, o_valid && o_prefetch.prefetch_valid,
        o_prefetch.prefetch_addr < r_limit)

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-neighbour delta prefetcher. A driver
// feeds access items from a queue with random gaps, a monitor takes prefetch
// results under random stall and compares them with a bit-exact predictor
// of the access log, the training walk and the neighbour choice. Several
// register settings are run, including a long output stall and a drained
// sender pause.
// ----------------------------------------------------------------------------
module tb;
    import kdp_pkg::*;

    localparam int DEPTH     = LOG_DEPTH_DEF;
    localparam int NBR       = NEIGHBOURS_DEF;
    localparam int IDLE_MAX  = 20000;
    localparam logic [32:0] FAR = 33'h1_0000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_access     i_access = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_prefetch   o_prefetch;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_WINDOW;
    logic [31:0] i_cfg_data = '0;

    knn_delta_prefetcher_top dut (.*);

    always #1 i_clk = ~i_clk;

    bit [31:0] log_pc [DEPTH];
    bit [31:0] log_addr [DEPTH];
    bit [47:0] log_time [DEPTH];
    bit [31:0] log_delta [DEPTH];
    bit        log_trained [DEPTH];
    int        log_wr = 0;
    int        log_fill = 0;
    bit [23:0] win_ticks = WINDOW_RESET;
    bit [31:0] addr_limit = LIMIT_RESET;

    t_access   pending_accesses[$];
    t_prefetch expected_prefetches[$];
    int        errors = 0;
    int        checked = 0;
    int        settings = 0;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        rx_hold = 0;
    bit        sender_pause = 1'b0;
    int        idle_cycles = 0;
    bit [47:0] t_now = '0;
    bit [31:0] a_now = '0;
    bit [31:0] pc_base [8];

    function automatic t_prefetch predict_prefetch(t_access a);
        int p;
        int left;
        bit below;
        bit [47:0] thr;
        logic [32:0] sdist [NBR];
        bit [31:0] sdelta [NBR];
        bit sused [NBR];
        logic [32:0] largest;
        logic [32:0] best;
        logic [32:0] d;
        int li;
        int chosen;
        t_prefetch r;
        p = (log_wr + DEPTH - 1) % DEPTH;
        below = a.access_time < {24'd0, win_ticks};
        thr = below ? 48'd0 : a.access_time - {24'd0, win_ticks};
        left = log_fill + 1;
        while (left > 0) begin
            if (below || log_time[p] <= thr) begin
                log_trained[p] = 1'b1;
                log_delta[p] = a.access_addr - log_addr[p];
                break;
            end
            p = (p + DEPTH - 1) % DEPTH;
            left--;
        end
        log_pc[log_wr] = a.access_pc;
        log_addr[log_wr] = a.access_addr;
        log_time[log_wr] = a.access_time;
        log_delta[log_wr] = '0;
        log_trained[log_wr] = 1'b0;
        for (int u = 0; u < NBR; u++) begin
            sused[u] = 1'b0;
            sdist[u] = '0;
            sdelta[u] = '0;
        end
        largest = FAR;
        li = 0;
        for (int i = 0; i < DEPTH; i++) begin
            d = (a.access_pc >= log_pc[i]) ? {1'b0, a.access_pc - log_pc[i]}
                                           : {1'b0, log_pc[i] - a.access_pc};
            if (log_trained[i] && d < largest) begin
                sused[li] = 1'b1;
                sdist[li] = d;
                sdelta[li] = log_delta[i];
                largest = '0;
                for (int u = 0; u < NBR; u++) begin
                    if (!sused[u]) begin
                        largest = FAR;
                        li = u;
                    end else if (sdist[u] > largest) begin
                        largest = sdist[u];
                        li = u;
                    end
                end
            end
        end
        best = FAR;
        chosen = -1;
        for (int u = 0; u < NBR; u++) begin
            if (sused[u] && sdist[u] < best) begin
                best = sdist[u];
                chosen = u;
            end
        end
        r = '0;
        if (chosen >= 0) begin
            r.prefetch_addr = a.access_addr + sdelta[chosen];
            r.prefetch_valid = r.prefetch_addr < addr_limit;
        end
        log_wr = (log_wr + 1) % DEPTH;
        log_fill = (log_fill + 1 >= DEPTH - 1) ? DEPTH - 1 : log_fill + 1;
        return r;
    endfunction

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            expected_prefetches.push_back(predict_prefetch(i_access));
            tx_gap = draw_gap();
            if (tx_gap == 0 && pending_accesses.size() > 0 && !sender_pause) begin
                i_access <= pending_accesses.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_accesses.size() > 0 && !sender_pause) begin
                i_access <= pending_accesses.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_prefetches.size() == 0) begin
                    $error("prefetch result with no access waiting");
                    errors++;
                end else begin
                    t_prefetch e;
                    e = expected_prefetches.pop_front();
                    checked++;
                    if (o_prefetch.prefetch_addr !== e.prefetch_addr) begin
                        $error("prefetch_addr: expected %h, got %h",
                               e.prefetch_addr, o_prefetch.prefetch_addr);
                        errors++;
                    end
                    if (o_prefetch.prefetch_valid !== e.prefetch_valid) begin
                        $error("prefetch_valid: expected %b, got %b",
                               e.prefetch_valid, o_prefetch.prefetch_valid);
                        errors++;
                    end
                end
                rx_gap = draw_gap();
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WINDOW) win_ticks = i_cfg_data[23:0];
            else addr_limit = i_cfg_data;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_MAX) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        wait (pending_accesses.size() == 0 && !i_valid &&
              expected_prefetches.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic push_access(input bit [31:0] pc, input bit [31:0] addr,
                               input bit [47:0] t);
        t_access a;
        a.access_pc = pc;
        a.access_addr = addr;
        a.access_time = t;
        pending_accesses.push_back(a);
    endtask

    task automatic push_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
                push_access($urandom, $urandom, 48'({$urandom, $urandom}));
            end else begin
                t_now = t_now + ((k == 1) ? $urandom_range(0, 200000)
                                          : $urandom_range(0, 3000));
                a_now = a_now + (($urandom_range(0, 1) == 1) ? 32'd64 : $urandom);
                push_access(pc_base[$urandom_range(0, 7)] + $urandom_range(0, 64),
                            a_now, t_now);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 8; i++) pc_base[i] = $urandom;
        pc_base[0] = 32'h0;
        pc_base[1] = 32'hFFFF_FF00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_access(32'h0000_0000, 32'h0000_0000, 48'd0);
        push_access(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd10);
        push_access(32'h0000_0000, 32'hFFFF_FFFF, 48'd4999);
        push_access(32'hFFFF_FFFF, 32'h0000_0000, 48'd5000);
        push_access(32'h0000_1000, 32'h8000_0000, 48'd10000);
        push_access(32'h0000_1004, 32'h8000_0040, 48'd10001);
        push_access(32'h0000_1008, 32'h8000_0080, 48'd20000);
        push_access(32'h0000_1004, 32'h8000_00C0, 48'd30000);
        push_access(32'h5555_5555, 32'hAAAA_AAAA, 48'h5555_5555_5555);
        push_access(32'hAAAA_AAAA, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
        push_access(32'h0000_1000, 32'hFFFF_FFC0, 48'hFFFF_FFFF_FFFF);
        push_access(32'h0000_1000, 32'h0000_0100, 48'hFFFF_FFFF_FFFF);
        push_access(32'h8000_0000, 32'h1234_5678, 48'd100);
        drain();
        write_reg(CFG_LIMIT, 32'd0);
        push_access(32'h0000_1000, 32'h0000_0010, 48'hFFFF_FFFF_FFFF);
        push_access(32'h0000_1004, 32'h0000_0020, 48'hFFFF_FFFF_FFFF);
        drain();
        write_reg(CFG_LIMIT, 32'd1);
        write_reg(CFG_WINDOW, 32'hFF00_0000);
        push_access(32'h0000_1000, 32'h0000_0000, 48'd0);
        push_access(32'h0000_1000, 32'h0000_0000, 48'd1);
        push_access(32'h0000_1000, 32'hFFFF_FFFF, 48'd1);
        drain();
        t_now = 48'd100000;

        write_reg(CFG_WINDOW, {8'd0, WINDOW_RESET});
        write_reg(CFG_LIMIT, LIMIT_RESET);
        push_random(90);
        drain();

        write_reg(CFG_WINDOW, {8'($urandom_range(0, 255)), 24'hFF_FFFF});
        rx_hold = 4000;
        push_random(90);
        drain();

        write_reg(CFG_WINDOW, 32'd1500);
        write_reg(CFG_LIMIT, 32'h8000_0000);
        push_random(45);
        wait (pending_accesses.size() == 0);
        sender_pause = 1'b1;
        push_random(45);
        wait (!i_valid && expected_prefetches.size() == 0);
        sender_pause = 1'b0;
        drain();

        write_reg(CFG_WINDOW, $urandom_range(0, 20000));
        write_reg(CFG_LIMIT, $urandom);
        push_random(90);
        drain();

        write_reg(CFG_WINDOW, 32'd0);
        write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
        push_random(90);
        drain();

        write_reg(CFG_WINDOW, 32'd300);
        write_reg(CFG_LIMIT, 32'h0000_0001);
        push_random(90);
        drain();

        repeat (2 * DEPTH + 20) @(posedge i_clk);
        $display("tb: %0d prefetch results checked across %0d register writes,",
                 checked, settings);
        $display("tb: with random gaps, a long output stall and a drained sender pause");
        if (errors == 0 && expected_prefetches.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
